// ----- sv/aarm_pkg.sv -----
`default_nettype none

package aarm_pkg;

  // Axis choice codes
  localparam logic [1:0] OP_ARB = 2'd0;
  localparam logic [1:0] OP_X   = 2'd1;
  localparam logic [1:0] OP_Y   = 2'd2;
  localparam logic [1:0] OP_Z   = 2'd3;

  // Normalizer: one root bit per sqrt step, one quotient bit per divide step
  localparam int unsigned SQ_STEPS = 30;
  localparam int unsigned DV_STEPS = 29;
  localparam int unsigned NORM_LAT = SQ_STEPS + DV_STEPS + 2;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;
  localparam logic signed [63:0] ONE_Q56 = 64'sh0100_0000_0000_0000;
  localparam logic signed [63:0] RND_Q42 = 64'sh0000_0200_0000_0000;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/aarm_cordic.sv -----
`default_nettype none

module aarm_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] angle_i,
  output logic signed [31:0]      w_o,
  output logic signed [31:0]      s_o
);
  import aarm_pkg::*;

  logic signed [33:0] x_q   [STAGES+1];
  logic signed [33:0] y_q   [STAGES+1];
  logic signed [33:0] z_q   [STAGES+1];
  logic               neg_q [STAGES+1];
  logic signed [33:0] h;
  logic signed [33:0] c_x;
  logic signed [33:0] c_y;
  logic signed [31:0] w_q;
  logic signed [31:0] s_q;

  // Half angle in Q30, folded into [-pi/2, pi/2]
  assign h = {angle_i[15], angle_i, 17'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GAIN_Q30;
      y_q[0] <= '0;
      if (h > HALF_PI_Q30) begin
        z_q[0]   <= h - PI_Q30;
        neg_q[0] <= 1'b1;
      end else if (h < -HALF_PI_Q30) begin
        z_q[0]   <= h + PI_Q30;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= h;
        neg_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_step
    logic signed [33:0] at;
    assign at = signed'({4'd0, atan_q30(5'(i))});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign c_x = neg_q[STAGES] ? -x_q[STAGES] : x_q[STAGES];
  assign c_y = neg_q[STAGES] ? -y_q[STAGES] : y_q[STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= c_x[33:2];
      s_q <= c_y[33:2];
    end
  end

  assign w_o = w_q;
  assign s_o = s_q;

endmodule

`default_nettype wire

// ----- sv/aarm_norm.sv -----
`default_nettype none

module aarm_norm (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [15:0] axis_x_i,
  input  wire logic signed [15:0] axis_y_i,
  input  wire logic signed [15:0] axis_z_i,
  output logic signed [31:0]      u_x_o,
  output logic signed [31:0]      u_y_o,
  output logic signed [31:0]      u_z_o,
  output logic                    zero_o
);
  import aarm_pkg::*;

  typedef struct packed {
    logic [31:0]      n2;
    logic [2:0][16:0] mag;
    logic [2:0]       sgn;
    logic [1:0]       op;
    logic             zero;
    logic [31:0]      rem;
    logic [29:0]      root;
  } sq_t;

  typedef struct packed {
    logic [29:0]      dvs;
    logic [2:0][31:0] rem;
    logic [2:0][28:0] quo;
    logic [2:0]       sgn;
    logic [1:0]       op;
    logic             zero;
  } dv_t;

  logic signed [15:0] a   [3];
  logic signed [31:0] sqr [3];
  sq_t                sq_q [SQ_STEPS+1];
  dv_t                dv_q [DV_STEPS];
  dv_t                dv_init;
  logic signed [31:0] u_q  [3];
  logic               zero_q;

  assign a[0] = axis_x_i;
  assign a[1] = axis_y_i;
  assign a[2] = axis_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqr[i] = a[i] * a[i];
    end
  end

  // Squared length, magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].n2   <= $unsigned(sqr[0]) + $unsigned(sqr[1]) + $unsigned(sqr[2]);
      sq_q[0].op   <= op_i;
      sq_q[0].zero <= (op_i == OP_ARB) && (axis_x_i == '0) && (axis_y_i == '0)
                      && (axis_z_i == '0);
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
      for (int i = 0; i < 3; i++) begin
        sq_q[0].sgn[i] <= a[i][15];
        sq_q[0].mag[i] <= a[i][15] ? (17'd0 - {a[i][15], a[i]}) : {1'b0, a[i]};
      end
    end
  end

  // Square root of n2 * 2^28, one root bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [1:0]  pair;
    logic [33:0] rs;
    logic [33:0] t;
    sq_t         nxt;

    if (k < 16) begin : g_hi
      assign pair = sq_q[k].n2[31-2*k -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    always_comb begin
      nxt = sq_q[k];
      rs  = {sq_q[k].rem, pair};
      t   = {2'b00, sq_q[k].root, 2'b01};
      if (rs >= t) begin
        nxt.rem  = 32'(rs - t);
        nxt.root = {sq_q[k].root[28:0], 1'b1};
      end else begin
        nxt.rem  = rs[31:0];
        nxt.root = {sq_q[k].root[28:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1] <= nxt;
      end
    end
  end

  // Dividend is |a| * 2^42; its top bits seed the remainder
  always_comb begin
    dv_init.dvs  = sq_q[SQ_STEPS].root;
    dv_init.sgn  = sq_q[SQ_STEPS].sgn;
    dv_init.op   = sq_q[SQ_STEPS].op;
    dv_init.zero = sq_q[SQ_STEPS].zero;
    for (int i = 0; i < 3; i++) begin
      dv_init.rem[i] = {2'b00, sq_q[SQ_STEPS].mag[i], 13'd0};
      dv_init.quo[i] = '0;
    end
  end

  for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
    dv_t         src;
    dv_t         nxt;
    logic [32:0] rs [3];

    if (j == 0) begin : g_first
      assign src = dv_init;
    end else begin : g_next
      assign src = dv_q[j-1];
    end

    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        rs[i] = {src.rem[i], 1'b0};
        if (rs[i] >= {3'b000, src.dvs}) begin
          nxt.rem[i] = 32'(rs[i] - {3'b000, src.dvs});
          nxt.quo[i] = {src.quo[i][27:0], 1'b1};
        end else begin
          nxt.rem[i] = rs[i][31:0];
          nxt.quo[i] = {src.quo[i][27:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= dv_q[DV_STEPS-1].zero;
      case (dv_q[DV_STEPS-1].op)
        OP_X: begin
          u_q[0] <= ONE_Q28;
          u_q[1] <= '0;
          u_q[2] <= '0;
        end
        OP_Y: begin
          u_q[0] <= '0;
          u_q[1] <= ONE_Q28;
          u_q[2] <= '0;
        end
        OP_Z: begin
          u_q[0] <= '0;
          u_q[1] <= '0;
          u_q[2] <= ONE_Q28;
        end
        default: begin
          for (int i = 0; i < 3; i++) begin
            u_q[i] <= dv_q[DV_STEPS-1].sgn[i]
                      ? -signed'({3'b000, dv_q[DV_STEPS-1].quo[i]})
                      : signed'({3'b000, dv_q[DV_STEPS-1].quo[i]});
          end
        end
      endcase
    end
  end

  assign u_x_o  = u_q[0];
  assign u_y_o  = u_q[1];
  assign u_z_o  = u_q[2];
  assign zero_o = zero_q;

endmodule

`default_nettype wire

// ----- sv/axis_angle_to_rotation_matrix.sv -----
`default_nettype none

// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    op_i, angle_i, axis_x_i, axis_y_i, axis_z_i
// output    out_valid_o / out_ready_i  m00_o .. m22_o, axis_zero_o
//
// One item per cycle while the output is not stalled; each item passes through
// 66 register stages, the input register included.
// The latency is set by the axis normalizer: a 30-step square root followed
// by a 29-step divider, one bit per stage; the CORDIC runs beside it.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline, and in_ready_o drops with it.

module axis_angle_to_rotation_matrix #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [15:0] angle_i,
  input  wire logic signed [15:0] axis_x_i,
  input  wire logic signed [15:0] axis_y_i,
  input  wire logic signed [15:0] axis_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      m00_o,
  output logic signed [15:0]      m01_o,
  output logic signed [15:0]      m02_o,
  output logic signed [15:0]      m10_o,
  output logic signed [15:0]      m11_o,
  output logic signed [15:0]      m12_o,
  output logic signed [15:0]      m20_o,
  output logic signed [15:0]      m21_o,
  output logic signed [15:0]      m22_o,
  output logic                    axis_zero_o
);
  import aarm_pkg::*;

  localparam int unsigned LAT = NORM_LAT + 5;
  localparam int unsigned DLY = NORM_LAT - (CORDIC_STAGES + 2);

  logic [LAT-1:0]     vld_q;
  logic               adv;
  logic [1:0]         op_q;
  logic signed [15:0] angle_q;
  logic signed [15:0] ax_q;
  logic signed [15:0] ay_q;
  logic signed [15:0] az_q;

  logic signed [31:0] cw;
  logic signed [31:0] cs;
  logic signed [31:0] wd_q [DLY];
  logic signed [31:0] sd_q [DLY];
  logic signed [31:0] u    [3];
  logic               nz;

  logic signed [63:0] p    [3];
  logic signed [31:0] q_q  [3];
  logic signed [31:0] w1_q;
  logic               z1_q;
  logic signed [63:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic               z2_q;
  logic signed [63:0] e_q  [9];
  logic               z3_q;
  logic signed [63:0] r    [9];
  logic signed [15:0] m_q  [9];
  logic               z4_q;

  assign adv        = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q    <= op_i;
      angle_q <= angle_i;
      ax_q    <= axis_x_i;
      ay_q    <= axis_y_i;
      az_q    <= axis_z_i;
    end
  end

  aarm_norm u_norm (
    .clk_i    (clk_i),
    .en_i     (adv),
    .op_i     (op_q),
    .axis_x_i (ax_q),
    .axis_y_i (ay_q),
    .axis_z_i (az_q),
    .u_x_o    (u[0]),
    .u_y_o    (u[1]),
    .u_z_o    (u[2]),
    .zero_o   (nz)
  );

  aarm_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .angle_i (angle_q),
    .w_o     (cw),
    .s_o     (cs)
  );

  // Hold sine and cosine until the unit axis catches up
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wd_q[0] <= cw;
      sd_q[0] <= cs;
      for (int i = 1; i < DLY; i++) begin
        wd_q[i] <= wd_q[i-1];
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = sd_q[DLY-1] * u[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q_q[i] <= p[i][59:28];
      end
      w1_q <= wd_q[DLY-1];
      z1_q <= nz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= q_q[0] * q_q[0];
      yy_q <= q_q[1] * q_q[1];
      zz_q <= q_q[2] * q_q[2];
      xy_q <= q_q[0] * q_q[1];
      xz_q <= q_q[0] * q_q[2];
      yz_q <= q_q[1] * q_q[2];
      wx_q <= w1_q * q_q[0];
      wy_q <= w1_q * q_q[1];
      wz_q <= w1_q * q_q[2];
      z2_q <= z1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q[0] <= ONE_Q56 - ((yy_q + zz_q) <<< 1);
      e_q[1] <= (xy_q - wz_q) <<< 1;
      e_q[2] <= (xz_q + wy_q) <<< 1;
      e_q[3] <= (xy_q + wz_q) <<< 1;
      e_q[4] <= ONE_Q56 - ((xx_q + zz_q) <<< 1);
      e_q[5] <= (yz_q - wx_q) <<< 1;
      e_q[6] <= (xz_q - wy_q) <<< 1;
      e_q[7] <= (yz_q + wx_q) <<< 1;
      e_q[8] <= ONE_Q56 - ((xx_q + yy_q) <<< 1);
      z3_q   <= z2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      r[i] = (e_q[i] + RND_Q42) >>> 42;
    end
  end

  // Round, saturate, and force identity for a zero-length axis
  always_ff @(posedge clk_i) begin
    if (adv) begin
      z4_q <= z3_q;
      for (int i = 0; i < 9; i++) begin
        if (z3_q) begin
          m_q[i] <= (i % 4 == 0) ? ONE_Q14 : '0;
        end else if (r[i] > 64'(ONE_Q14)) begin
          m_q[i] <= ONE_Q14;
        end else if (r[i] < -64'(ONE_Q14)) begin
          m_q[i] <= -ONE_Q14;
        end else begin
          m_q[i] <= r[i][15:0];
        end
      end
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign m00_o       = m_q[0];
  assign m01_o       = m_q[1];
  assign m02_o       = m_q[2];
  assign m10_o       = m_q[3];
  assign m11_o       = m_q[4];
  assign m12_o       = m_q[5];
  assign m20_o       = m_q[6];
  assign m21_o       = m_q[7];
  assign m22_o       = m_q[8];
  assign axis_zero_o = z4_q;

endmodule

`default_nettype wire
